@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sts_pkg.sv @@
// shared constants, widths and angle helpers for the segment tilt/azimuth block
package sts_pkg;

  // parameter defaults
  localparam int unsigned MAX_SEGMENTS_DEF = 65536;
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned COUNT_LIMIT      = 131071;
  localparam int unsigned STEPS_LIMIT      = 32;

  // widths
  localparam int COORD_W = 32;
  localparam int DX_W    = 33;
  localparam int NV_W    = 36;
  localparam int CW      = 38;
  localparam int ZW      = 34;
  localparam int ANG_W   = 35;
  localparam int SQ_W    = 64;
  localparam int MUL_W   = 32;
  localparam int QUO_W   = 20;
  localparam int DSTEP_W = 5;
  localparam int DEN_W   = 68;
  localparam int REM_W   = 64;
  localparam int STEP_W  = 6;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 33;
  localparam int RES_W   = 34;
  localparam int UNIT_W  = 21;
  localparam int TILT_W  = 15;
  localparam int AZ_W    = 16;
  localparam int CFG_W   = 32;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 48;

  // constants
  localparam logic [MUL_W-1:0]        GAIN_Q30   = 32'd1768195374;
  localparam logic [TILT_W-1:0]       TILT_MAX   = 15'd11520;
  localparam logic [16:0]             TURN_Q7    = 17'd46080;
  localparam logic signed [ANG_W-1:0] DEG180_Q24 = 35'sd3019898880;
  localparam logic signed [ANG_W-1:0] DEG360_Q24 = 35'sd6039797760;
  localparam logic [CFG_W-1:0]        MIN_LEN_RST = 32'd4295;

  // result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // atan(2^-i) in Q8.24 degrees
  function automatic logic [31:0] atan_q24(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // saturating 64-bit add
  function automatic logic [SQ_W-1:0] sat_add64(input logic [SQ_W-1:0] a,
                                                 input logic [SQ_W-1:0] b);
    logic [SQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
  endfunction

  // Q8.24 degrees to rounded Q9.7, negative clamps to zero
  function automatic logic [16:0] q24_to_q7(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] s;
    if (a < 0) begin
      s = '0;
    end else begin
      s = a + 35'sd65536;
    end
    return s[33:17];
  endfunction

  // tilt from the second rotation angle, clamped to a quarter turn
  function automatic logic [TILT_W-1:0] tilt_q7(input logic signed [ZW-1:0] z);
    logic [16:0] q;
    q = q24_to_q7({{(ANG_W-ZW){z[ZW-1]}}, z});
    if (q > {2'b00, TILT_MAX}) begin
      q = {2'b00, TILT_MAX};
    end
    return q[TILT_W-1:0];
  endfunction

  // clockwise azimuth from north, folded into [0,360)
  function automatic logic [AZ_W-1:0] azimuth_q7(input logic signed [ZW-1:0] z,
                                                  input logic north_neg);
    logic signed [ANG_W-1:0] ang;
    logic [16:0] q;
    ang = {{(ANG_W-ZW){z[ZW-1]}}, z};
    if (north_neg) begin
      ang = DEG180_Q24 - ang;
    end
    if (ang < 0) begin
      ang = ang + DEG360_Q24;
    end
    q = q24_to_q7(ang);
    if (q >= TURN_Q7) begin
      q = q - TURN_Q7;
    end
    return q[AZ_W-1:0];
  endfunction

endpackage

@@ rtl/segment_tilt_azimuth_stats_top.sv @@
// segment tilt/azimuth engine with running set statistics on one shared cordic and divider
//
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+------------------------------------------
// in_      | in  | in_tvalid/in_tready   | tdata: 6 x Q16.16 coords, tlast: last seg
// out_     | out | out_tvalid/out_tready | tdata: tilt, az, resultant az; tuser, tlast
// cfg_     | in  | cfg_valid/cfg_ready   | cfg_data: min_length_sq
//
// a segment runs the squares, then normalize and two cordic rotations for the tilt (when
// long enough), normalize and a rotation for the azimuth, and two divides for the unit
// vector; a last segment adds two divides, one more normalize and a rotation for the summary.
// the single cordic stage does one micro-rotation a cycle and the divider one quotient
// bit a cycle. in_tready is high only while the sequencer is idle;
// a result waiting in the output register does not block the next transfer in.
// rst_n is synchronous, clears control state and statistics, and sets min_length_sq to MIN_LEN_RST.
module segment_tilt_azimuth_stats_top #(
  parameter int unsigned MAX_SEGMENTS = sts_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned CORDIC_STEPS = sts_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  logic [sts_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tilt_deg[14:0], azimuth_deg[30:15], resultant_azimuth_deg[46:31], zero pad
  output logic [sts_pkg::OUT_DATA_W-1:0]   out_tdata,
  // result_kind
  output logic                             out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sts_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  localparam logic [sts_pkg::STEP_W-1:0] STEPS_USED = sts_pkg::STEP_W'(
    (CORDIC_STEPS > sts_pkg::STEPS_LIMIT) ? sts_pkg::STEPS_LIMIT : CORDIC_STEPS);
  localparam logic [sts_pkg::CNT_W-1:0] COUNT_CAP = sts_pkg::CNT_W'(
    (MAX_SEGMENTS > sts_pkg::COUNT_LIMIT) ? sts_pkg::COUNT_LIMIT : MAX_SEGMENTS);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ0    = 4'd1;
  localparam logic [3:0] S_SQ1    = 4'd2;
  localparam logic [3:0] S_SQ2    = 4'd3;
  localparam logic [3:0] S_SQ3    = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_CORD   = 4'd6;
  localparam logic [3:0] S_KZ_MUL = 4'd7;
  localparam logic [3:0] S_KZ     = 4'd8;
  localparam logic [3:0] S_UMUL   = 4'd9;
  localparam logic [3:0] S_ULOAD  = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_STAT   = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;
  localparam logic [3:0] S_MEAN   = 4'd14;
  localparam logic [3:0] S_EMIT2  = 4'd15;

  // cordic jobs
  localparam logic [1:0] J_TILT  = 2'd0;
  localparam logic [1:0] J_TILT2 = 2'd1;
  localparam logic [1:0] J_AZ    = 2'd2;
  localparam logic [1:0] J_RES   = 2'd3;

  // divider jobs
  localparam logic [1:0] D_UE = 2'd0;
  localparam logic [1:0] D_UN = 2'd1;
  localparam logic [1:0] D_MT = 2'd2;
  localparam logic [1:0] D_MA = 2'd3;

  localparam logic signed [sts_pkg::RES_W:0] RES_MAX = 35'sd8589934591;
  localparam logic signed [sts_pkg::RES_W:0] RES_MIN = -35'sd8589934592;
  localparam logic [sts_pkg::SUM_W-1:0] SUM_MAX = {sts_pkg::SUM_W{1'b1}};

  logic [3:0] state_r, state_nxt;
  logic [1:0] job_r, job_nxt;
  logic [1:0] djob_r, djob_nxt;
  logic       last_r, last_nxt;

  logic signed [sts_pkg::DX_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [sts_pkg::SQ_W-1:0]        sq_r, sq_nxt;
  logic                            xy_ok_r, xy_ok_nxt;
  logic [sts_pkg::SQ_W-1:0]        mul_p_r, mul_p_nxt;
  logic [sts_pkg::MUL_W-1:0]       mul_a, mul_b;

  logic signed [sts_pkg::NV_W-1:0] nv0_r, nv0_nxt, nv1_r, nv1_nxt, nv2_r, nv2_nxt;
  logic signed [sts_pkg::CW-1:0]   cx_r, cx_nxt, cy_r, cy_nxt, len_r, len_nxt;
  logic signed [sts_pkg::ZW-1:0]   cz_r, cz_nxt;
  logic [sts_pkg::STEP_W-1:0]      step_r, step_nxt;

  logic [sts_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [sts_pkg::DEN_W-1:0]       dd_r, dd_nxt;
  logic [sts_pkg::QUO_W-1:0]       quo_r, quo_nxt;
  logic [sts_pkg::DSTEP_W-1:0]     dstep_r, dstep_nxt;

  logic [sts_pkg::TILT_W-1:0]      tilt_r, tilt_nxt, mt_r, mt_nxt;
  logic [sts_pkg::AZ_W-1:0]        az_r, az_nxt, ma_r, ma_nxt;
  logic signed [sts_pkg::UNIT_W-1:0] ue_r, ue_nxt, un_r, un_nxt;

  logic [sts_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [sts_pkg::SUM_W-1:0]       tsum_r, tsum_nxt, asum_r, asum_nxt;
  logic signed [sts_pkg::RES_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [sts_pkg::CFG_W-1:0]       min_len_r, min_len_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic [sts_pkg::TILT_W-1:0]      out_tilt_r, out_tilt_nxt;
  logic [sts_pkg::AZ_W-1:0]        out_az_r, out_az_nxt, out_raz_r, out_raz_nxt;

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_raz_r, out_az_r, out_tilt_r};

  // shared 32x32 multiplier operand select
  always_comb begin
    logic signed [sts_pkg::DX_W-1:0] mag_d;
    logic signed [sts_pkg::NV_W-1:0] mag_n;
    mag_d = '0;
    mag_n = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ0, S_SQ1, S_SQ2: begin
        mag_d = (state_r == S_SQ0) ? dx_r : ((state_r == S_SQ1) ? dy_r : dz_r);
        if (mag_d < 0) begin
          mag_d = -mag_d;
        end
        mul_a = mag_d[sts_pkg::MUL_W-1:0];
        mul_b = mag_d[sts_pkg::MUL_W-1:0];
      end
      S_KZ_MUL: begin
        mul_a = nv2_r[sts_pkg::MUL_W-1:0];
        mul_b = sts_pkg::GAIN_Q30;
      end
      S_UMUL: begin
        mag_n = (djob_r == D_UE) ? nv0_r : nv1_r;
        if (mag_n < 0) begin
          mag_n = -mag_n;
        end
        mul_a = mag_n[sts_pkg::MUL_W-1:0];
        mul_b = sts_pkg::GAIN_Q30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p_nxt = mul_a * mul_b;

  // sequencer and datapath
  always_comb begin
    logic signed [sts_pkg::DX_W-1:0] fx, fy, fz, sx, sy, sz;
    logic [sts_pkg::SQ_W-1:0]        sq_sum;
    logic [sts_pkg::NV_W-1:0]        m0, m1, m2;
    logic                            nz, big, tiny;
    logic signed [sts_pkg::CW-1:0]   xs, ys;
    logic signed [sts_pkg::ZW-1:0]   at;
    logic [sts_pkg::DEN_W-1:0]       rem_ext;
    logic [sts_pkg::SQ_W:0]          kz_sum;
    logic signed [sts_pkg::UNIT_W-1:0] uq;
    logic                            u_neg;
    logic signed [sts_pkg::RES_W:0]  rsum;
    logic [sts_pkg::SUM_W:0]         ssum;
    logic                            free;

    state_nxt = state_r;
    job_nxt   = job_r;
    djob_nxt  = djob_r;
    last_nxt  = last_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    sq_nxt = sq_r; xy_ok_nxt = xy_ok_r;
    nv0_nxt = nv0_r; nv1_nxt = nv1_r; nv2_nxt = nv2_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; step_nxt = step_r; len_nxt = len_r;
    rem_nxt = rem_r; dd_nxt = dd_r; quo_nxt = quo_r; dstep_nxt = dstep_r;
    tilt_nxt = tilt_r; az_nxt = az_r; mt_nxt = mt_r; ma_nxt = ma_r;
    ue_nxt = ue_r; un_nxt = un_r;
    count_nxt = count_r; tsum_nxt = tsum_r; asum_nxt = asum_r;
    rx_nxt = rx_r; ry_nxt = ry_r;
    min_len_nxt = min_len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt = out_kind_r; out_last_nxt = out_last_r;
    out_tilt_nxt = out_tilt_r; out_az_nxt = out_az_r; out_raz_nxt = out_raz_r;

    free = !out_valid_r || out_tready;

    fx = {in_tdata[31], in_tdata[31:0]};
    fy = {in_tdata[63], in_tdata[63:32]};
    fz = {in_tdata[95], in_tdata[95:64]};
    sx = {in_tdata[127], in_tdata[127:96]};
    sy = {in_tdata[159], in_tdata[159:128]};
    sz = {in_tdata[191], in_tdata[191:160]};

    sq_sum = sts_pkg::sat_add64(sq_r, mul_p_r);

    // normalize tests
    m0 = (nv0_r < 0) ? -nv0_r : nv0_r;
    m1 = (nv1_r < 0) ? -nv1_r : nv1_r;
    m2 = (nv2_r < 0) ? -nv2_r : nv2_r;
    nz   = (m0 != '0) || (m1 != '0) || (m2 != '0);
    big  = (m0[sts_pkg::NV_W-1:31] != '0) || (m1[sts_pkg::NV_W-1:31] != '0)
        || (m2[sts_pkg::NV_W-1:31] != '0);
    tiny = (m0[sts_pkg::NV_W-1:30] == '0) && (m1[sts_pkg::NV_W-1:30] == '0)
        && (m2[sts_pkg::NV_W-1:30] == '0);

    // cordic micro-rotation terms
    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    at = {2'b00, sts_pkg::atan_q24(step_r[4:0])};

    rem_ext = {{(sts_pkg::DEN_W-sts_pkg::REM_W){1'b0}}, rem_r};
    kz_sum  = {1'b0, mul_p_r} + 65'd536870912;

    // signed unit component from the quotient
    u_neg = (djob_r == D_UE) ? nv0_r[sts_pkg::NV_W-1] : nv1_r[sts_pkg::NV_W-1];
    uq = $signed({1'b0, quo_r});
    if (len_r <= 0) begin
      uq = '0;
    end else if (u_neg) begin
      uq = -uq;
    end

    rsum = '0;
    ssum = '0;

    // configuration write
    if (cfg_valid) begin
      min_len_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (fz > sz) begin
            dx_nxt = fx - sx; dy_nxt = fy - sy; dz_nxt = fz - sz;
          end else begin
            dx_nxt = sx - fx; dy_nxt = sy - fy; dz_nxt = sz - fz;
          end
          last_nxt  = in_tlast;
          state_nxt = S_SQ0;
        end
      end
      S_SQ0: state_nxt = S_SQ1;
      S_SQ1: begin
        sq_nxt    = mul_p_r;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        sq_nxt    = sq_sum;
        xy_ok_nxt = (sq_sum >= {32'd0, min_len_r});
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        nv0_nxt = {{3{dx_r[sts_pkg::DX_W-1]}}, dx_r};
        nv1_nxt = {{3{dy_r[sts_pkg::DX_W-1]}}, dy_r};
        tilt_nxt = '0;
        if (sq_sum >= {32'd0, min_len_r}) begin
          nv2_nxt = {{3{dz_r[sts_pkg::DX_W-1]}}, dz_r};
          job_nxt = J_TILT;
        end else begin
          nv2_nxt = '0;
          job_nxt = J_AZ;
        end
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (!nz) begin
          // all-zero vector
          case (job_r)
            J_TILT: begin
              tilt_nxt = '0;
              nv0_nxt = {{3{dx_r[sts_pkg::DX_W-1]}}, dx_r};
              nv1_nxt = {{3{dy_r[sts_pkg::DX_W-1]}}, dy_r};
              nv2_nxt = '0;
              job_nxt = J_AZ;
            end
            J_AZ: begin
              az_nxt = '0; ue_nxt = '0; un_nxt = '0;
              state_nxt = S_STAT;
            end
            default: begin
              az_nxt = '0;
              state_nxt = S_EMIT2;
            end
          endcase
        end else if (big) begin
          // halve, rounding toward zero
          nv0_nxt = (nv0_r + $signed({{(sts_pkg::NV_W-1){1'b0}}, nv0_r[sts_pkg::NV_W-1]})) >>> 1;
          nv1_nxt = (nv1_r + $signed({{(sts_pkg::NV_W-1){1'b0}}, nv1_r[sts_pkg::NV_W-1]})) >>> 1;
          nv2_nxt = (nv2_r + $signed({{(sts_pkg::NV_W-1){1'b0}}, nv2_r[sts_pkg::NV_W-1]})) >>> 1;
        end else if (tiny) begin
          nv0_nxt = nv0_r <<< 1;
          nv1_nxt = nv1_r <<< 1;
          nv2_nxt = nv2_r <<< 1;
        end else begin
          cx_nxt = {2'b00, m1};
          cy_nxt = {{2{nv0_r[sts_pkg::NV_W-1]}}, nv0_r};
          cz_nxt = '0;
          step_nxt = '0;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        if (step_r == STEPS_USED) begin
          case (job_r)
            J_TILT: begin
              len_nxt = cx_r;
              state_nxt = S_KZ_MUL;
            end
            J_TILT2: begin
              tilt_nxt = sts_pkg::tilt_q7(cz_r);
              nv0_nxt = {{3{dx_r[sts_pkg::DX_W-1]}}, dx_r};
              nv1_nxt = {{3{dy_r[sts_pkg::DX_W-1]}}, dy_r};
              nv2_nxt = '0;
              job_nxt = J_AZ;
              state_nxt = S_NORM;
            end
            J_AZ: begin
              az_nxt = sts_pkg::azimuth_q7(cz_r, nv1_r[sts_pkg::NV_W-1]);
              len_nxt = cx_r;
              djob_nxt = D_UE;
              state_nxt = S_UMUL;
            end
            default: begin
              az_nxt = sts_pkg::azimuth_q7(cz_r, nv1_r[sts_pkg::NV_W-1]);
              state_nxt = S_EMIT2;
            end
          endcase
        end else begin
          if (cy_r > 0) begin
            cx_nxt = cx_r + ys; cy_nxt = cy_r - xs; cz_nxt = cz_r + at;
          end else begin
            cx_nxt = cx_r - ys; cy_nxt = cy_r + xs; cz_nxt = cz_r - at;
          end
          step_nxt = step_r + 1'b1;
        end
      end
      S_KZ_MUL: state_nxt = S_KZ;
      S_KZ: begin
        // round(v2 * gain) as the x input of the second rotation
        cx_nxt = $signed({4'b0000, kz_sum[63:30]});
        cy_nxt = len_r;
        cz_nxt = '0;
        step_nxt = '0;
        job_nxt = J_TILT2;
        state_nxt = S_CORD;
      end
      S_UMUL: state_nxt = S_ULOAD;
      S_ULOAD: begin
        rem_nxt = mul_p_r + ({30'd0, len_r[33:0]} << 13);
        dd_nxt  = {34'd0, len_r[33:0]} << 33;
        quo_nxt = '0;
        dstep_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dstep_r == sts_pkg::DSTEP_W'(sts_pkg::QUO_W)) begin
          case (djob_r)
            D_UE: begin
              ue_nxt = uq;
              djob_nxt = D_UN;
              state_nxt = S_UMUL;
            end
            D_UN: begin
              un_nxt = uq;
              state_nxt = S_STAT;
            end
            D_MT: begin
              mt_nxt = quo_r[sts_pkg::TILT_W-1:0];
              rem_nxt = {30'd0, {1'b0, asum_r} + {18'd0, count_r[sts_pkg::CNT_W-1:1]}};
              dd_nxt = {32'd0, count_r, 19'd0};
              quo_nxt = '0;
              dstep_nxt = '0;
              djob_nxt = D_MA;
            end
            default: begin
              ma_nxt = quo_r[sts_pkg::AZ_W-1:0];
              nv0_nxt = {{2{rx_r[sts_pkg::RES_W-1]}}, rx_r};
              nv1_nxt = {{2{ry_r[sts_pkg::RES_W-1]}}, ry_r};
              nv2_nxt = '0;
              job_nxt = J_RES;
              state_nxt = S_NORM;
            end
          endcase
        end else begin
          // one restoring quotient bit
          if (rem_ext >= dd_r) begin
            rem_nxt = rem_r - dd_r[sts_pkg::REM_W-1:0];
            quo_nxt = {quo_r[sts_pkg::QUO_W-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_r[sts_pkg::QUO_W-2:0], 1'b0};
          end
          dd_nxt = dd_r >> 1;
          dstep_nxt = dstep_r + 1'b1;
        end
      end
      S_STAT: begin
        if (count_r < COUNT_CAP) begin
          count_nxt = count_r + 1'b1;
          ssum = {1'b0, tsum_r} + {19'd0, tilt_r};
          tsum_nxt = ssum[sts_pkg::SUM_W] ? SUM_MAX : ssum[sts_pkg::SUM_W-1:0];
          ssum = {1'b0, asum_r} + {18'd0, az_r};
          asum_nxt = ssum[sts_pkg::SUM_W] ? SUM_MAX : ssum[sts_pkg::SUM_W-1:0];
          if (xy_ok_r) begin
            rsum = {rx_r[sts_pkg::RES_W-1], rx_r}
                 + {{(sts_pkg::RES_W+1-sts_pkg::UNIT_W){ue_r[sts_pkg::UNIT_W-1]}}, ue_r};
            rx_nxt = (rsum > RES_MAX) ? RES_MAX[sts_pkg::RES_W-1:0]
                   : ((rsum < RES_MIN) ? RES_MIN[sts_pkg::RES_W-1:0]
                   : rsum[sts_pkg::RES_W-1:0]);
            rsum = {ry_r[sts_pkg::RES_W-1], ry_r}
                 + {{(sts_pkg::RES_W+1-sts_pkg::UNIT_W){un_r[sts_pkg::UNIT_W-1]}}, un_r};
            ry_nxt = (rsum > RES_MAX) ? RES_MAX[sts_pkg::RES_W-1:0]
                   : ((rsum < RES_MIN) ? RES_MIN[sts_pkg::RES_W-1:0]
                   : rsum[sts_pkg::RES_W-1:0]);
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sts_pkg::KIND_SEGMENT;
          out_tilt_nxt  = tilt_r;
          out_az_nxt    = az_r;
          out_raz_nxt   = '0;
          out_last_nxt  = !last_r;
          state_nxt     = last_r ? S_MEAN : S_IDLE;
        end
      end
      S_MEAN: begin
        if (count_r == '0) begin
          mt_nxt = '0;
          ma_nxt = '0;
          nv0_nxt = {{2{rx_r[sts_pkg::RES_W-1]}}, rx_r};
          nv1_nxt = {{2{ry_r[sts_pkg::RES_W-1]}}, ry_r};
          nv2_nxt = '0;
          job_nxt = J_RES;
          state_nxt = S_NORM;
        end else begin
          rem_nxt = {30'd0, {1'b0, tsum_r} + {18'd0, count_r[sts_pkg::CNT_W-1:1]}};
          dd_nxt = {32'd0, count_r, 19'd0};
          quo_nxt = '0;
          dstep_nxt = '0;
          djob_nxt = D_MT;
          state_nxt = S_DIV;
        end
      end
      S_EMIT2: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sts_pkg::KIND_SUMMARY;
          out_tilt_nxt  = mt_r;
          out_az_nxt    = ma_r;
          out_raz_nxt   = az_r;
          out_last_nxt  = 1'b1;
          count_nxt = '0; tsum_nxt = '0; asum_nxt = '0; rx_nxt = '0; ry_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      tsum_r      <= '0;
      asum_r      <= '0;
      rx_r        <= '0;
      ry_r        <= '0;
      min_len_r   <= sts_pkg::MIN_LEN_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      tsum_r      <= tsum_nxt;
      asum_r      <= asum_nxt;
      rx_r        <= rx_nxt;
      ry_r        <= ry_nxt;
      min_len_r   <= min_len_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt; djob_r <= djob_nxt; last_r <= last_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    sq_r <= sq_nxt; xy_ok_r <= xy_ok_nxt; mul_p_r <= mul_p_nxt;
    nv0_r <= nv0_nxt; nv1_r <= nv1_nxt; nv2_r <= nv2_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; step_r <= step_nxt; len_r <= len_nxt;
    rem_r <= rem_nxt; dd_r <= dd_nxt; quo_r <= quo_nxt; dstep_r <= dstep_nxt;
    tilt_r <= tilt_nxt; az_r <= az_nxt; mt_r <= mt_nxt; ma_r <= ma_nxt;
    ue_r <= ue_nxt; un_r <= un_nxt;
    out_kind_r <= out_kind_nxt; out_last_r <= out_last_nxt;
    out_tilt_r <= out_tilt_nxt; out_az_r <= out_az_nxt; out_raz_r <= out_raz_nxt;
  end

endmodule

@@ rtl/sts_chk.sv @@
// port-level checker for the segment tilt/azimuth block, bound to the top level
`include "assert_macros.svh"

module sts_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic [sts_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // a stalled result transfer holds its payload
  `STS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a summary always closes the run
  `STS_ASSERT_SAME(a_sum_last, clk, rst_n, out_tvalid && (out_tuser == sts_pkg::KIND_SUMMARY), out_tlast)

  // segment results carry no resultant azimuth
  `STS_ASSERT_SAME(a_seg_raz, clk, rst_n, out_tvalid && (out_tuser == sts_pkg::KIND_SEGMENT), out_tdata[46:31] == '0)

  // tilt never exceeds a quarter turn
  `STS_ASSERT_SAME(a_tilt_max, clk, rst_n, out_tvalid, out_tdata[14:0] <= sts_pkg::TILT_MAX)

  // azimuth stays below a full turn
  `STS_ASSERT_SAME(a_az_max, clk, rst_n, out_tvalid, {1'b0, out_tdata[30:15]} < sts_pkg::TURN_Q7)

endmodule

bind segment_tilt_azimuth_stats_top sts_chk u_sts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ test/tb_segment_tilt_azimuth_stats_top.sv @@
// self-checking testbench for the segment tilt/azimuth statistics block
module tb_segment_tilt_azimuth_stats_top;
  import sts_pkg::*;

  localparam int SEG_CAP = 65536;
  localparam int N_STEPS = 24;

  typedef struct packed {
    logic [31:0] ax, ay, az, bx, by, bz;
    logic        last;
  } segment_t;

  typedef struct packed {
    logic        kind;
    logic [14:0] tilt;
    logic [15:0] azim;
    logic [15:0] res_azim;
    logic        eor;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0, in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser, out_tlast, out_tvalid;
  logic out_tready = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  segment_t pending_segs[$];
  angles_t  expected_angles[$];
  int  mismatch_count = 0;
  bit  idle_enable = 1'b1;
  bit  hold_sink = 1'b0;
  int  src_gap = 0, sink_gap = 0;

  // predictor state
  longint unsigned min_len_sq;
  longint unsigned seg_cnt, tilt_acc, azim_acc;
  longint res_e, res_n;

  segment_tilt_azimuth_stats_top uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint asr_trunc(longint v, int s);
    return v >= 0 ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
    return (a + b < a) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[32] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342, 58671,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // common power-of-two scaling so the largest magnitude sits in [2^30, 2^31)
  function automatic bit scale_vec(ref longint v[3], input int n);
    longint m;
    m = 0;
    for (int i = 0; i < n; i++) if (iabs(v[i]) > m) m = iabs(v[i]);
    if (m == 0) return 1'b0;
    while (m >= (64'sd1 <<< 31)) begin
      for (int i = 0; i < n; i++) v[i] = asr_trunc(v[i], 1);
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 30)) begin
      for (int i = 0; i < n; i++) v[i] = v[i] * 2;
      m = m * 2;
    end
    return 1'b1;
  endfunction

  // vectoring rotation: angle in q8.24 degrees, gain-scaled magnitude
  function automatic longint rotate_vec(longint x, longint y, output longint mag);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < N_STEPS; i++) begin
      xs = asr_floor(x, i);
      ys = asr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_tab(i);
      end else begin
        x -= ys; y += xs; z -= atan_tab(i);
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint unit_comp(longint c, longint mag);
    longint unsigned num, den, q;
    if (mag <= 0) return 0;
    num = longint'(iabs(c)) * 64'd1768195374;
    den = longint'(mag) << 14;
    q = (num + den / 2) / den;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned deg_q7(longint a);
    if (a < 0) a = 0;
    return (a + 65536) >>> 17;
  endfunction

  function automatic longint unsigned heading_q7(longint e, longint n, output longint ue,
                                                 output longint un);
    longint v[3], mag, ang;
    longint unsigned q;
    v[0] = e; v[1] = n; v[2] = 0;
    ue = 0; un = 0;
    if (!scale_vec(v, 2)) return 0;
    ang = rotate_vec(iabs(v[1]), v[0], mag);
    if (v[1] < 0) ang = (64'sd180 <<< 24) - ang;
    if (ang < 0) ang += (64'sd360 <<< 24);
    ue = unit_comp(v[0], mag);
    un = unit_comp(v[1], mag);
    q = deg_q7(ang);
    if (q >= 46080) q -= 46080;
    return q;
  endfunction

  function automatic longint clamp34(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< 33) - 1;
    lo = -(64'sd1 <<< 33);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned add_sat33(longint unsigned a, longint unsigned b);
    longint unsigned top;
    top = (64'd1 << 33) - 1;
    return a + b > top ? top : a + b;
  endfunction

  // work out the results of one segment and queue them
  task automatic predict_angles(segment_t s);
    longint fx, fy, fz, sx, sy, sz, dx, dy, dz, ue, un, m1, dmy, kz, t, e2, n2;
    longint v[3];
    longint unsigned sq_xy, sq_all, tilt, azim, mt, ma;
    angles_t r;
    fx = longint'(signed'(s.ax)); fy = longint'(signed'(s.ay)); fz = longint'(signed'(s.az));
    sx = longint'(signed'(s.bx)); sy = longint'(signed'(s.by)); sz = longint'(signed'(s.bz));
    if (fz > sz) begin
      dx = fx - sx; dy = fy - sy; dz = fz - sz;
    end else begin
      dx = sx - fx; dy = sy - fy; dz = sz - fz;
    end
    sq_xy = add_sat64(iabs(dx) * iabs(dx), iabs(dy) * iabs(dy));
    sq_all = add_sat64(sq_xy, iabs(dz) * iabs(dz));
    tilt = 0;
    if (sq_all >= min_len_sq) begin
      v[0] = dx; v[1] = dy; v[2] = dz;
      if (scale_vec(v, 3)) begin
        void'(rotate_vec(iabs(v[1]), v[0], m1));
        kz = longint'((longint'(v[2]) * 64'd1768195374 + (64'd1 << 29)) >> 30);
        t = rotate_vec(kz, m1, dmy);
        tilt = deg_q7(t);
        if (tilt > 11520) tilt = 11520;
      end
    end
    azim = heading_q7(dx, dy, ue, un);
    if (seg_cnt < SEG_CAP) begin
      seg_cnt++;
      tilt_acc = add_sat33(tilt_acc, tilt);
      azim_acc = add_sat33(azim_acc, azim);
      if (sq_xy >= min_len_sq) begin
        res_e = clamp34(res_e + ue);
        res_n = clamp34(res_n + un);
      end
    end
    r.kind = KIND_SEGMENT; r.tilt = tilt[14:0]; r.azim = azim[15:0];
    r.res_azim = '0; r.eor = !s.last;
    expected_angles.push_back(r);
    if (s.last) begin
      mt = 0; ma = 0;
      if (seg_cnt != 0) begin
        mt = (tilt_acc + seg_cnt / 2) / seg_cnt;
        ma = (azim_acc + seg_cnt / 2) / seg_cnt;
      end
      r.kind = KIND_SUMMARY; r.tilt = mt[14:0]; r.azim = ma[15:0];
      r.res_azim = 16'(heading_q7(res_e, res_n, e2, n2)); r.eor = 1'b1;
      expected_angles.push_back(r);
      seg_cnt = 0; tilt_acc = 0; azim_acc = 0; res_e = 0; res_n = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // driver: offers queued segments, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_angles(pending_segs.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_tvalid <= 1'b0;
      end else if ((!in_tvalid || in_tready) && idle_enable && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else if (!in_tvalid || in_tready) begin
        if ((in_tvalid && in_tready ? pending_segs.size() : pending_segs.size()) > 0) begin
          in_tdata <= {pending_segs[0].bz, pending_segs[0].by, pending_segs[0].bx,
                       pending_segs[0].az, pending_segs[0].ay, pending_segs[0].ax};
          in_tlast <= pending_segs[0].last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares every result transfer, random back-pressure
  always @(posedge clk) begin
    angles_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_angles.pop_front();
          if (out_tuser !== w.kind) report_mismatch("kind", out_tuser, w.kind);
          if (out_tdata[14:0] !== w.tilt) report_mismatch("tilt", out_tdata[14:0], w.tilt);
          if (out_tdata[30:15] !== w.azim)
            report_mismatch("azimuth", out_tdata[30:15], w.azim);
          if (out_tdata[46:31] !== w.res_azim)
            report_mismatch("resultant azimuth", out_tdata[46:31], w.res_azim);
          if (out_tlast !== w.eor) report_mismatch("end of run", out_tlast, w.eor);
        end
      end
      if (hold_sink) begin
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      2: return 32'(int'($urandom_range(0, 40000)) - 20000);
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic segment_t rand_seg(bit last);
    segment_t s;
    s.ax = rand_coord(); s.ay = rand_coord(); s.az = rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      s.bx = s.ax + 32'($urandom_range(0, 3)); s.by = s.ay; s.bz = s.az;
    end else begin
      s.bx = rand_coord(); s.by = rand_coord(); s.bz = rand_coord();
    end
    s.last = last;
    return s;
  endfunction

  function automatic segment_t mk(int ax, int ay, int az, int bx, int by, int bz, bit l);
    segment_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.bx = bx; s.by = by; s.bz = bz; s.last = l;
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_segs.size() > 0 || in_tvalid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] val);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_len_sq = val;
  endtask

  task automatic queue_sets(int n);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len && left > 0; i++) begin
        pending_segs.push_back(rand_seg(i == len - 1 || left == 1));
        left--;
      end
    end
  endtask

  initial begin
    int big;
    min_len_sq = 4295;
    seg_cnt = 0; tilt_acc = 0; azim_acc = 0; res_e = 0; res_n = 0;
    big = 32'h7FFF_FFFF;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axes, quadrants, extremes, zero and short segments, one-segment run
    pending_segs.push_back(mk(0, 0, 0, 0, 0, 65536, 0));
    pending_segs.push_back(mk(0, 0, 0, 65536, 0, 0, 0));
    pending_segs.push_back(mk(0, 0, 0, 0, 65536, 0, 0));
    pending_segs.push_back(mk(0, 0, 0, -65536, 0, 0, 0));
    pending_segs.push_back(mk(0, 0, 0, 0, -65536, 0, 0));
    pending_segs.push_back(mk(0, 0, 65536, 65536, 65536, 0, 0));
    pending_segs.push_back(mk(5, 5, 5, 5, 5, 5, 0));
    pending_segs.push_back(mk(0, 0, 0, 1, 0, 1, 0));
    pending_segs.push_back(mk(-big - 1, -big - 1, -big - 1, big, big, big, 0));
    pending_segs.push_back(mk(big, -big - 1, 0, -big - 1, big, 0, 0));
    pending_segs.push_back(mk(0, 0, big, 1, 0, -big - 1, 0));
    pending_segs.push_back(mk(0, 0, 0, -65536, 1, 3, 1));
    pending_segs.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    pending_segs.push_back(mk(65536, 0, 0, -65536, 0, 0, 0));
    pending_segs.push_back(mk(0, 0, 0, 65536, 0, 0, 1));
    wait_drained();

    write_threshold(32'd0);
    pending_segs.push_back(mk(0, 0, 0, 1, 0, 0, 0));
    pending_segs.push_back(mk(0, 0, 0, 0, 0, 1, 1));
    queue_sets(120);
    wait_drained();

    write_threshold(32'hFFFF_FFFF);
    queue_sets(100);
    wait_drained();

    // receiver stalls for a long stretch while segments keep coming
    write_threshold(32'd4295);
    queue_sets(30);
    hold_sink = 1'b1;
    repeat (3000) @(posedge clk);
    hold_sink = 1'b0;
    queue_sets(150);
    wait_drained();

    write_threshold($urandom);
    queue_sets(100);
    while (pending_segs.size() > 40) @(posedge clk);
    idle_enable = 1'b0;
    wait_drained();

    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/sts_pkg.sv
rtl/segment_tilt_azimuth_stats_top.sv
rtl/sts_chk.sv
test/tb_segment_tilt_azimuth_stats_top.sv
